/* hw/rtl/bbip_pkg.sv */
package bbip_pkg;

  // Default sizing of the block.
  localparam int SSID_MAX_BYTES_DEF = 32;
  localparam int RATE_SLOTS_DEF     = 16;
  localparam int MIN_BODY_BYTES_DEF = 36;
  localparam int MAX_BODY_BYTES_DEF = 4095;

  // Result kinds carried on the output channel.
  localparam logic [1:0] KIND_SUMMARY = 2'd0;
  localparam logic [1:0] KIND_SSID    = 2'd1;
  localparam logic [1:0] KIND_RATE    = 2'd2;

  // Information element identifiers of interest.
  localparam logic [7:0] EID_SSID      = 8'd0;
  localparam logic [7:0] EID_RATES     = 8'd1;
  localparam logic [7:0] EID_HT        = 8'd45;
  localparam logic [7:0] EID_EXT_RATES = 8'd50;
  localparam logic [7:0] EID_VHT       = 8'd191;
  localparam logic [7:0] EID_EXT       = 8'd255;
  localparam logic [7:0] EXT_ID_HE     = 8'd35;

  // Width of the packed result data word.
  localparam int OUT_DATA_W = 120;

  // Per-frame summary handed from the element walker to the result emitter.
  typedef struct packed {
    logic        frame_ok;
    logic [63:0] timestamp;
    logic [15:0] beacon_interval;
    logic [15:0] capability;
    logic        has_ht;
    logic        has_vht;
    logic        has_he;
    logic        ssid_bank;
  } frame_sum_t;

endpackage

/* hw/rtl/bbip_store.sv */
module bbip_store
  import bbip_pkg::*;
#(
  parameter int SSID_MAX_BYTES = SSID_MAX_BYTES_DEF,
  parameter int RATE_SLOTS     = RATE_SLOTS_DEF,
  localparam int SAW = $clog2(2 * SSID_MAX_BYTES),
  localparam int RAW = (RATE_SLOTS > 1) ? $clog2(RATE_SLOTS) : 1
) (
  input  logic           clk,
  input  logic           ssid_we,
  input  logic [SAW-1:0] ssid_waddr,
  input  logic [7:0]     ssid_wdata,
  input  logic           rate_we,
  input  logic [RAW-1:0] rate_waddr,
  input  logic [6:0]     rate_wdata,
  input  logic           rd_en,
  input  logic [SAW-1:0] ssid_raddr,
  input  logic [RAW-1:0] rate_raddr,
  output logic [7:0]     ssid_rdata,
  output logic [6:0]     rate_rdata
);

  // Two SSID banks: one holds the committed name, the other the one being received.
  logic [7:0] ssid_mem [2*SSID_MAX_BYTES];
  logic [6:0] rate_mem [RATE_SLOTS];

  logic [7:0] ssid_rdata_r;
  logic [6:0] rate_rdata_r;

  // Write ports.
  always_ff @(posedge clk) begin
    if (ssid_we) begin
      ssid_mem[ssid_waddr] <= ssid_wdata;
    end
    if (rate_we) begin
      rate_mem[rate_waddr] <= rate_wdata;
    end
  end

  // Registered read ports; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ssid_rdata_r <= ssid_mem[ssid_raddr];
      rate_rdata_r <= rate_mem[rate_raddr];
    end
  end

  assign ssid_rdata = ssid_rdata_r;
  assign rate_rdata = rate_rdata_r;

endmodule

/* hw/rtl/bbip_walker.sv */
module bbip_walker
  import bbip_pkg::*;
#(
  parameter int SSID_MAX_BYTES = SSID_MAX_BYTES_DEF,
  parameter int RATE_SLOTS     = RATE_SLOTS_DEF,
  parameter int MIN_BODY_BYTES = MIN_BODY_BYTES_DEF,
  parameter int MAX_BODY_BYTES = MAX_BODY_BYTES_DEF,
  localparam int SAW  = $clog2(2 * SSID_MAX_BYTES),
  localparam int RAW  = (RATE_SLOTS > 1) ? $clog2(RATE_SLOTS) : 1,
  localparam int SLW  = $clog2(SSID_MAX_BYTES + 1),
  localparam int RCW  = $clog2(RATE_SLOTS + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           byte_en,
  input  logic [7:0]     data_byte,
  input  logic           frame_done,
  output frame_sum_t     sum,
  output logic [SLW-1:0] ssid_len,
  output logic [RCW-1:0] rate_cnt,
  output logic           ssid_we,
  output logic [SAW-1:0] ssid_waddr,
  output logic [7:0]     ssid_wdata,
  output logic           rate_we,
  output logic [RAW-1:0] rate_waddr,
  output logic [6:0]     rate_wdata
);

  localparam int CNTW = $clog2(MAX_BODY_BYTES + 1);

  localparam logic [1:0] PH_ID   = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  localparam logic [8:0] SSID_MAX_L = 9'(SSID_MAX_BYTES);

  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [63:0]     ts_r, ts_nxt;
  logic [31:0]     ic_r, ic_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [7:0]      id_r, id_nxt;
  logic [7:0]      len_r, len_nxt;
  logic [7:0]      pos_r, pos_nxt;
  logic            bank_r, bank_nxt;
  logic [SLW-1:0]  slen_r, slen_nxt;
  logic [RCW-1:0]  rc_r, rc_nxt;
  logic [RCW-1:0]  rt_r, rt_nxt;
  logic [2:0]      flags_r, flags_nxt;
  logic            he_t_r, he_t_nxt;
  logic            fin;

  // Byte parser: fixed fields first, then the element walk.
  always_comb begin
    cnt_nxt    = cnt_r;
    ts_nxt     = ts_r;
    ic_nxt     = ic_r;
    phase_nxt  = phase_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    bank_nxt   = bank_r;
    slen_nxt   = slen_r;
    rc_nxt     = rc_r;
    rt_nxt     = rt_r;
    flags_nxt  = flags_r;
    he_t_nxt   = he_t_r;
    fin        = 1'b0;
    ssid_we    = 1'b0;
    rate_we    = 1'b0;
    // Received SSID bytes go to the bank that is not committed.
    ssid_waddr = bank_r ? SAW'(pos_r) : SAW'(pos_r) + SAW'(SSID_MAX_BYTES);
    ssid_wdata = data_byte;
    rate_waddr = rt_r[RAW-1:0];
    rate_wdata = data_byte[6:0];

    if (frame_done) begin
      cnt_nxt   = '0;
      phase_nxt = PH_ID;
      id_nxt    = '0;
      len_nxt   = '0;
      pos_nxt   = '0;
      bank_nxt  = 1'b0;
      slen_nxt  = '0;
      rc_nxt    = '0;
      rt_nxt    = '0;
      flags_nxt = '0;
      he_t_nxt  = 1'b0;
    end else if (byte_en) begin
      if (cnt_r < CNTW'(8)) begin
        ts_nxt[{cnt_r[2:0], 3'b000} +: 8] = data_byte;
      end else if (cnt_r < CNTW'(12)) begin
        ic_nxt[{cnt_r[1:0], 3'b000} +: 8] = data_byte;
      end else begin
        unique case (phase_r)
          PH_ID: begin
            id_nxt    = data_byte;
            len_nxt   = '0;
            pos_nxt   = '0;
            rt_nxt    = rc_r;
            he_t_nxt  = 1'b0;
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            len_nxt = data_byte;
            pos_nxt = '0;
            if (data_byte == 8'd0) begin
              fin = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            if (id_r == EID_SSID && {1'b0, len_r} <= SSID_MAX_L &&
                {1'b0, pos_r} < SSID_MAX_L) begin
              ssid_we = 1'b1;
            end else if ((id_r == EID_RATES || id_r == EID_EXT_RATES) &&
                         rt_r < RCW'(RATE_SLOTS)) begin
              rate_we = 1'b1;
              rt_nxt  = rt_r + 1'b1;
            end else if (id_r == EID_EXT && pos_r == 8'd0 && data_byte == EXT_ID_HE) begin
              he_t_nxt = 1'b1;
            end
            pos_nxt = pos_r + 8'd1;
            fin     = (pos_nxt >= len_r);
          end
          default: begin
            phase_nxt = PH_ID;
          end
        endcase

        // A complete element commits its tentative effects.
        if (fin) begin
          phase_nxt = PH_ID;
          case (id_r) inside
            EID_SSID: begin
              if ({1'b0, len_nxt} <= SSID_MAX_L) begin
                bank_nxt = ~bank_r;
                slen_nxt = SLW'(len_nxt);
              end
            end
            EID_RATES, EID_EXT_RATES: begin
              rc_nxt = rt_nxt;
            end
            EID_HT: begin
              flags_nxt[0] = 1'b1;
            end
            EID_VHT: begin
              flags_nxt[1] = 1'b1;
            end
            EID_EXT: begin
              flags_nxt[2] = flags_r[2] | he_t_nxt;
            end
            default: begin
            end
          endcase
        end
      end

      // Byte counter saturates.
      if (cnt_r < CNTW'(MAX_BODY_BYTES)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      phase_r <= PH_ID;
      id_r    <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      bank_r  <= 1'b0;
      slen_r  <= '0;
      rc_r    <= '0;
      rt_r    <= '0;
      flags_r <= '0;
      he_t_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      bank_r  <= bank_nxt;
      slen_r  <= slen_nxt;
      rc_r    <= rc_nxt;
      rt_r    <= rt_nxt;
      flags_r <= flags_nxt;
      he_t_r  <= he_t_nxt;
    end
  end

  // Fixed fields: every byte is written before a frame can be reported as parsed.
  always_ff @(posedge clk) begin
    ts_r <= ts_nxt;
    ic_r <= ic_nxt;
  end

  assign sum.frame_ok        = (cnt_r >= CNTW'(MIN_BODY_BYTES));
  assign sum.timestamp       = ts_r;
  assign sum.beacon_interval = ic_r[15:0];
  assign sum.capability      = ic_r[31:16];
  assign sum.has_ht          = flags_r[0];
  assign sum.has_vht         = flags_r[1];
  assign sum.has_he          = flags_r[2];
  assign sum.ssid_bank       = bank_r;
  assign ssid_len            = slen_r;
  assign rate_cnt            = rc_r;

  // Committed rates never run ahead of the tentative count or past the slots.
  a_rate_order: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r <= rt_r && rt_r <= RCW'(RATE_SLOTS))
    else $error("rate counts out of order");

  // The committed SSID length fits one bank.
  a_ssid_len: assert property (@(posedge clk) disable iff (!rst_n)
    slen_r <= SLW'(SSID_MAX_BYTES))
    else $error("SSID length exceeds bank size");

  // The end of a result run returns the walker to the start of a frame.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> cnt_r == '0 && phase_r == PH_ID && rc_r == '0)
    else $error("frame state not cleared after run");

endmodule

/* hw/rtl/bbip_emitter.sv */
module bbip_emitter
  import bbip_pkg::*;
#(
  parameter int SSID_MAX_BYTES = SSID_MAX_BYTES_DEF,
  parameter int RATE_SLOTS     = RATE_SLOTS_DEF,
  localparam int SAW  = $clog2(2 * SSID_MAX_BYTES),
  localparam int RAW  = (RATE_SLOTS > 1) ? $clog2(RATE_SLOTS) : 1,
  localparam int SLW  = $clog2(SSID_MAX_BYTES + 1),
  localparam int RCW  = $clog2(RATE_SLOTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  frame_done,
  output logic                  busy,
  input  frame_sum_t            sum,
  input  logic [SLW-1:0]        ssid_len,
  input  logic [RCW-1:0]        rate_cnt,
  output logic                  rd_en,
  output logic [SAW-1:0]        ssid_raddr,
  output logic [RAW-1:0]        rate_raddr,
  input  logic [7:0]            ssid_rdata,
  input  logic [6:0]            rate_rdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic [1:0]            out_tuser
);

  localparam int CW = (SLW > RCW) ? SLW : RCW;

  localparam logic [2:0] P_IDLE  = 3'd0;
  localparam logic [2:0] P_SUM   = 3'd1;
  localparam logic [2:0] P_SSID  = 3'd2;
  localparam logic [2:0] P_RATE  = 3'd3;
  localparam logic [2:0] P_DRAIN = 3'd4;

  logic [2:0]    phase_r, phase_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] ssid_n;
  logic [CW-1:0] rate_n;
  logic          p_r;
  logic [1:0]    p_kind_r;
  logic          p_last_r;
  logic          load;
  logic          can_issue;
  logic          issue;
  logic [1:0]    iss_kind;
  logic          iss_last;

  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic          out_last_r;
  logic [7:0]    out_value_r;
  logic          out_ok_r;
  logic [63:0]   out_ts_r;
  logic [15:0]   out_bi_r;
  logic [15:0]   out_cap_r;
  logic          out_ht_r;
  logic          out_vht_r;
  logic          out_he_r;
  logic [5:0]    out_slen_r;
  logic [4:0]    out_rcnt_r;

  assign ssid_n  = CW'(ssid_len);
  assign rate_n  = CW'(rate_cnt);
  assign idx_inc = idx_r + CW'(1);

  // The pending stage holds one item whose memory data is in the read register.
  assign load      = p_r && (!out_valid_r || out_tready);
  assign can_issue = !p_r || load;

  // Sequencer: summary, then SSID bytes, then rates.
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    issue     = 1'b0;
    iss_kind  = KIND_SUMMARY;
    iss_last  = 1'b0;
    unique case (phase_r)
      P_IDLE: begin
        if (start) begin
          phase_nxt = P_SUM;
        end
      end
      P_SUM: begin
        if (can_issue) begin
          issue   = 1'b1;
          idx_nxt = '0;
          if (!sum.frame_ok || (ssid_n == '0 && rate_n == '0)) begin
            iss_last  = 1'b1;
            phase_nxt = P_DRAIN;
          end else if (ssid_n != '0) begin
            phase_nxt = P_SSID;
          end else begin
            phase_nxt = P_RATE;
          end
        end
      end
      P_SSID: begin
        if (can_issue) begin
          issue    = 1'b1;
          iss_kind = KIND_SSID;
          if (idx_inc == ssid_n) begin
            idx_nxt = '0;
            if (rate_n == '0) begin
              iss_last  = 1'b1;
              phase_nxt = P_DRAIN;
            end else begin
              phase_nxt = P_RATE;
            end
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      P_RATE: begin
        if (can_issue) begin
          issue    = 1'b1;
          iss_kind = KIND_RATE;
          if (idx_inc == rate_n) begin
            idx_nxt   = '0;
            iss_last  = 1'b1;
            phase_nxt = P_DRAIN;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      P_DRAIN: begin
        if (load && p_last_r) begin
          phase_nxt = P_IDLE;
        end
      end
      default: begin
        phase_nxt = P_IDLE;
      end
    endcase
  end

  // Memory reads for SSID and rate items; the committed SSID bank is selected.
  assign rd_en      = issue && (iss_kind != KIND_SUMMARY);
  assign ssid_raddr = sum.ssid_bank ? SAW'(SSID_MAX_BYTES) + SAW'(idx_r) : SAW'(idx_r);
  assign rate_raddr = idx_r[RAW-1:0];

  assign frame_done = load && p_last_r;
  assign busy       = (phase_r != P_IDLE);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= P_IDLE;
      idx_r       <= '0;
      p_r         <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      if (issue) begin
        p_r <= 1'b1;
      end else if (load) begin
        p_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pending item tags.
  always_ff @(posedge clk) begin
    if (issue) begin
      p_kind_r <= iss_kind;
      p_last_r <= iss_last;
    end
  end

  // Output register; summary fields read as zero for a short body.
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r <= p_kind_r;
      out_last_r <= p_last_r;
      case (p_kind_r)
        KIND_SSID: out_value_r <= ssid_rdata;
        KIND_RATE: out_value_r <= {1'b0, rate_rdata};
        default:   out_value_r <= 8'd0;
      endcase
      out_ok_r   <= sum.frame_ok;
      out_ts_r   <= sum.frame_ok ? sum.timestamp : 64'd0;
      out_bi_r   <= sum.frame_ok ? sum.beacon_interval : 16'd0;
      out_cap_r  <= sum.frame_ok ? sum.capability : 16'd0;
      out_ht_r   <= sum.frame_ok & sum.has_ht;
      out_vht_r  <= sum.frame_ok & sum.has_vht;
      out_he_r   <= sum.frame_ok & sum.has_he;
      out_slen_r <= sum.frame_ok ? 6'(ssid_len) : 6'd0;
      out_rcnt_r <= sum.frame_ok ? 5'(rate_cnt) : 5'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {1'b0, out_rcnt_r, out_slen_r, out_he_r, out_vht_r, out_ht_r,
                       out_cap_r, out_bi_r, out_ts_r, out_ok_r, out_value_r};

  // A new frame only starts a run when the previous one has finished.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> phase_r == P_IDLE)
    else $error("run started while busy");

  // A pending item is never overwritten before it moves to the output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    issue && p_r |-> load)
    else $error("pending item overwritten");

  // After the final transfer is loaded the sequencer is empty.
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> phase_r == P_IDLE && !p_r)
    else $error("sequencer not empty after run");

endmodule

/* hw/rtl/beacon_body_ie_parser_top.sv */
// Beacon frame body parser.
//
// The input channel takes the frame body one byte per transfer, starting at the
// timestamp; in_tlast marks the final byte. Each byte is absorbed as it is taken,
// so bytes stream in at one per cycle for the whole body.
// On the final byte the block produces a run on the output channel: one
// summary transfer, then one transfer per SSID byte, then one per rate
// (at most 1 + SSID_MAX_BYTES + RATE_SLOTS transfers). The summary passes through
// the sequencer, the pending stage and the output register; the following results
// come at one per cycle while the receiver is ready, as a two-entry issue/output
// pipeline hides the registered reads of the SSID and rate memories. out_tlast
// marks the last result. While a run is in progress in_tready is low; it returns
// as the final result enters the output register, so the next frame may start
// while that result still waits to be taken. A stalled receiver simply holds
// the output register and the run pauses. Reset clears all control state; the
// memories need no clearing since only committed entries are read.
module beacon_body_ie_parser_top
  import bbip_pkg::*;
#(
  parameter int SSID_MAX_BYTES = SSID_MAX_BYTES_DEF,
  parameter int RATE_SLOTS     = RATE_SLOTS_DEF,
  parameter int MIN_BODY_BYTES = MIN_BODY_BYTES_DEF,
  parameter int MAX_BODY_BYTES = MAX_BODY_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // last_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] item_value, [8] frame_ok, [72:9] timestamp, [88:73] beacon_interval,
  // [104:89] capability, [105] has_ht, [106] has_vht, [107] has_he,
  // [113:108] ssid_length, [118:114] rate_count, [119] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // run_last
  output logic [1:0]            out_tuser   // [1:0] kind
);

  localparam int SAW = $clog2(2 * SSID_MAX_BYTES);
  localparam int RAW = (RATE_SLOTS > 1) ? $clog2(RATE_SLOTS) : 1;
  localparam int SLW = $clog2(SSID_MAX_BYTES + 1);
  localparam int RCW = $clog2(RATE_SLOTS + 1);

  logic           in_xfer;
  logic           start;
  logic           busy;
  logic           frame_done;
  frame_sum_t     sum;
  logic [SLW-1:0] ssid_len;
  logic [RCW-1:0] rate_cnt;
  logic           ssid_we;
  logic [SAW-1:0] ssid_waddr;
  logic [7:0]     ssid_wdata;
  logic           rate_we;
  logic [RAW-1:0] rate_waddr;
  logic [6:0]     rate_wdata;
  logic           rd_en;
  logic [SAW-1:0] ssid_raddr;
  logic [RAW-1:0] rate_raddr;
  logic [7:0]     ssid_rdata;
  logic [6:0]     rate_rdata;

  // Input transfers are taken whenever no result run is in progress.
  assign in_tready = !busy;
  assign in_xfer   = in_tvalid && in_tready;
  assign start     = in_xfer && in_tlast;

  bbip_walker #(
    .SSID_MAX_BYTES (SSID_MAX_BYTES),
    .RATE_SLOTS     (RATE_SLOTS),
    .MIN_BODY_BYTES (MIN_BODY_BYTES),
    .MAX_BODY_BYTES (MAX_BODY_BYTES)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (in_xfer),
    .data_byte  (in_tdata),
    .frame_done (frame_done),
    .sum        (sum),
    .ssid_len   (ssid_len),
    .rate_cnt   (rate_cnt),
    .ssid_we    (ssid_we),
    .ssid_waddr (ssid_waddr),
    .ssid_wdata (ssid_wdata),
    .rate_we    (rate_we),
    .rate_waddr (rate_waddr),
    .rate_wdata (rate_wdata)
  );

  bbip_store #(
    .SSID_MAX_BYTES (SSID_MAX_BYTES),
    .RATE_SLOTS     (RATE_SLOTS)
  ) u_store (
    .clk        (clk),
    .ssid_we    (ssid_we),
    .ssid_waddr (ssid_waddr),
    .ssid_wdata (ssid_wdata),
    .rate_we    (rate_we),
    .rate_waddr (rate_waddr),
    .rate_wdata (rate_wdata),
    .rd_en      (rd_en),
    .ssid_raddr (ssid_raddr),
    .rate_raddr (rate_raddr),
    .ssid_rdata (ssid_rdata),
    .rate_rdata (rate_rdata)
  );

  bbip_emitter #(
    .SSID_MAX_BYTES (SSID_MAX_BYTES),
    .RATE_SLOTS     (RATE_SLOTS)
  ) u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .frame_done (frame_done),
    .busy       (busy),
    .sum        (sum),
    .ssid_len   (ssid_len),
    .rate_cnt   (rate_cnt),
    .rd_en      (rd_en),
    .ssid_raddr (ssid_raddr),
    .rate_raddr (rate_raddr),
    .ssid_rdata (ssid_rdata),
    .rate_rdata (rate_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* tb/sv/beacon_report_checker.sv */
`timescale 1ns / 100ps

module beacon_report_checker
  import bbip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // last_byte
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] item_value, [8] frame_ok, [72:9] timestamp, [88:73] beacon_interval,
  // [104:89] capability, [105] has_ht, [106] has_vht, [107] has_he,
  // [113:108] ssid_length, [118:114] rate_count, [119] zero
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,  // run_last
  input  logic [1:0]            out_tuser,  // [1:0] kind
  output int unsigned           mismatch_count,
  output int unsigned           reports_pending
);

  localparam int SSID_MAX = SSID_MAX_BYTES_DEF;
  localparam int RATE_MAX = RATE_SLOTS_DEF;
  localparam int MIN_BODY = MIN_BODY_BYTES_DEF;
  localparam int MAX_BODY = MAX_BODY_BYTES_DEF;

  typedef enum logic [1:0] {
    WALK_ID,
    WALK_LEN,
    WALK_DATA
  } ie_walk_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  item_value;
    logic        run_last;
    logic        frame_ok;
    logic [63:0] timestamp;
    logic [15:0] beacon_interval;
    logic [15:0] capability;
    logic        has_ht;
    logic        has_vht;
    logic        has_he;
    logic [5:0]  ssid_length;
    logic [4:0]  rate_count;
  } beacon_report_t;

  // Shadow copy of the parser state.
  logic [11:0] body_count;
  logic [63:0] tsf;
  logic [31:0] ivl_cap;
  ie_walk_e    walk;
  logic [7:0]  ie_id;
  logic [7:0]  ie_len;
  logic [7:0]  ie_pos;
  logic [7:0]  ssid_mem [0:2*SSID_MAX-1];
  logic        ssid_sel;
  logic [5:0]  ssid_len_c;
  logic [6:0]  rate_mem [0:RATE_MAX-1];
  logic [4:0]  rates_c;
  logic [4:0]  rates_t;
  logic        ht_c;
  logic        vht_c;
  logic        he_c;
  logic        he_t;

  beacon_report_t report_q[$];
  int unsigned    fails;

  task clear_frame_state();
    body_count = '0;
    tsf        = '0;
    ivl_cap    = '0;
    walk       = WALK_ID;
    ie_id      = '0;
    ie_len     = '0;
    ie_pos     = '0;
    ssid_sel   = 1'b0;
    ssid_len_c = '0;
    rates_c    = '0;
    rates_t    = '0;
    ht_c       = 1'b0;
    vht_c      = 1'b0;
    he_c       = 1'b0;
    he_t       = 1'b0;
  endtask

  // A complete element commits whatever it carried.
  task close_element();
    if (ie_id == EID_SSID) begin
      if (ie_len <= SSID_MAX) begin
        ssid_sel   = ~ssid_sel;
        ssid_len_c = ie_len[5:0];
      end
    end else if (ie_id == EID_RATES || ie_id == EID_EXT_RATES) begin
      rates_c = rates_t;
    end else if (ie_id == EID_HT) begin
      ht_c = 1'b1;
    end else if (ie_id == EID_VHT) begin
      vht_c = 1'b1;
    end else if (ie_id == EID_EXT) begin
      he_c = he_c | he_t;
    end
    walk = WALK_ID;
  endtask

  // One byte of the element walk; SSID bytes go to the bank not yet committed.
  task walk_element(input logic [7:0] b);
    case (walk)
      WALK_ID: begin
        ie_id   = b;
        ie_len  = '0;
        ie_pos  = '0;
        rates_t = rates_c;
        he_t    = 1'b0;
        walk    = WALK_LEN;
      end
      WALK_LEN: begin
        ie_len = b;
        if (b == 8'd0) close_element();
        else walk = WALK_DATA;
      end
      default: begin
        if (ie_id == EID_SSID && ie_len <= SSID_MAX && ie_pos < SSID_MAX) begin
          ssid_mem[{~ssid_sel, ie_pos[4:0]}] = b;
        end else if ((ie_id == EID_RATES || ie_id == EID_EXT_RATES) && rates_t < RATE_MAX) begin
          rate_mem[rates_t[3:0]] = b[6:0];
          rates_t = rates_t + 5'd1;
        end else if (ie_id == EID_EXT && ie_pos == 8'd0 && b == EXT_ID_HE) begin
          he_t = 1'b1;
        end
        ie_pos = ie_pos + 8'd1;
        if (ie_pos >= ie_len) close_element();
      end
    endcase
  endtask

  function automatic beacon_report_t make_report(input logic [1:0] kind,
                                                 input logic [7:0] value,
                                                 input logic ok, input logic last);
    beacon_report_t r;
    r            = '0;
    r.kind       = kind;
    r.item_value = value;
    r.run_last   = last;
    r.frame_ok   = ok;
    if (ok) begin
      r.timestamp       = tsf;
      r.beacon_interval = ivl_cap[15:0];
      r.capability      = ivl_cap[31:16];
      r.has_ht          = ht_c;
      r.has_vht         = vht_c;
      r.has_he          = he_c;
      r.ssid_length     = ssid_len_c;
      r.rate_count      = rates_c;
    end
    return r;
  endfunction

  // Absorb one accepted body byte; the final byte queues the whole result run.
  task absorb_byte(input logic [7:0] b, input logic last);
    int i;
    int k;
    int total;
    if (body_count < 8) begin
      tsf[8*body_count[2:0] +: 8] = b;
    end else if (body_count < 12) begin
      ivl_cap[8*body_count[1:0] +: 8] = b;
    end else begin
      walk_element(b);
    end
    if (body_count < MAX_BODY) body_count = body_count + 12'd1;

    if (last) begin
      if (body_count < MIN_BODY) begin
        report_q.push_back(make_report(KIND_SUMMARY, 8'd0, 1'b0, 1'b1));
      end else begin
        total = 1 + ssid_len_c + rates_c;
        k = 1;
        report_q.push_back(make_report(KIND_SUMMARY, 8'd0, 1'b1, total == 1));
        for (i = 0; i < ssid_len_c; i++) begin
          k++;
          report_q.push_back(make_report(KIND_SSID, ssid_mem[{ssid_sel, i[4:0]}], 1'b1,
                                         k == total));
        end
        for (i = 0; i < rates_c; i++) begin
          k++;
          report_q.push_back(make_report(KIND_RATE, {1'b0, rate_mem[i[3:0]]}, 1'b1,
                                         k == total));
        end
      end
      clear_frame_state();
    end
  endtask

  function automatic bit field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Compare one result transfer against the oldest queued report.
  task check_result();
    beacon_report_t want;
    bit bad;
    if (report_q.size() == 0) begin
      $error("result transfer with nothing expected: kind %0d value 0x%0h",
             out_tuser, out_tdata[7:0]);
      fails++;
    end else begin
      want = report_q.pop_front();
      bad  = 1'b0;
      bad |= field_differs("kind", want.kind, out_tuser);
      bad |= field_differs("item_value", want.item_value, out_tdata[7:0]);
      bad |= field_differs("run_last", want.run_last, out_tlast);
      bad |= field_differs("frame_ok", want.frame_ok, out_tdata[8]);
      bad |= field_differs("timestamp", want.timestamp, out_tdata[72:9]);
      bad |= field_differs("beacon_interval", want.beacon_interval, out_tdata[88:73]);
      bad |= field_differs("capability", want.capability, out_tdata[104:89]);
      bad |= field_differs("has_ht", want.has_ht, out_tdata[105]);
      bad |= field_differs("has_vht", want.has_vht, out_tdata[106]);
      bad |= field_differs("has_he", want.has_he, out_tdata[107]);
      bad |= field_differs("ssid_length", want.ssid_length, out_tdata[113:108]);
      bad |= field_differs("rate_count", want.rate_count, out_tdata[118:114]);
      if (bad) fails++;
    end
  endtask

  // Watch both channels at every rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame_state();
      report_q.delete();
      fails = 0;
      mismatch_count  <= 0;
      reports_pending <= 0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) absorb_byte(in_tdata, in_tlast);
      mismatch_count  <= fails;
      reports_pending <= report_q.size();
    end
  end

endmodule

/* tb/sv/tb_beacon_body_ie_parser_top.sv */
`timescale 1ns / 100ps

module tb_beacon_body_ie_parser_top;
  import bbip_pkg::*;

  localparam int         CYCLE_LIMIT      = 1_000_000;
  localparam int         MAX_WAIT         = 18;
  localparam int         LONG_HOLD_CYCLES = 400;
  localparam int         LONG_HOLD_AFTER  = 60;
  localparam int         RANDOM_FRAMES    = 24;
  localparam int         DRAIN_CYCLES     = 40;
  localparam logic [7:0] EID_VENDOR       = 8'd221;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic [1:0]            out_tuser;

  int unsigned mismatch_count;
  int unsigned reports_pending;
  int unsigned cycle_count = 0;
  int          tx_quiet = 0;
  int          rx_quiet = 0;
  logic [7:0]  body_q[$];

  beacon_body_ie_parser_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  beacon_report_checker u_report_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .out_tuser       (out_tuser),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("beacon_body_ie_parser_top: mismatch");
      $finish;
    end
  end

  // Idle cycles before the next transfer, with occasional stretches of none.
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet = $urandom_range(20, 80);
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Frame body construction helpers.
  task begin_body(input logic [63:0] tsf, input logic [15:0] ivl, input logic [15:0] cap);
    int i;
    body_q.delete();
    for (i = 0; i < 8; i++) body_q.push_back(tsf[8*i +: 8]);
    body_q.push_back(ivl[7:0]);
    body_q.push_back(ivl[15:8]);
    body_q.push_back(cap[7:0]);
    body_q.push_back(cap[15:8]);
  endtask

  task add_ie(input logic [7:0] id, input logic [7:0] len, input int first_data);
    int i;
    body_q.push_back(id);
    body_q.push_back(len);
    for (i = 0; i < len; i++) begin
      if (i == 0 && first_data >= 0) body_q.push_back(first_data[7:0]);
      else body_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Vendor elements up to the target length (one short when a single byte remains).
  task pad_body(input int target);
    int n;
    while (body_q.size() + 2 <= target) begin
      n = target - body_q.size() - 2;
      if (n > 255) n = 255;
      add_ie(EID_VENDOR, n[7:0], -1);
    end
  endtask

  task cut_body(input int keep);
    while (body_q.size() > keep) body_q.pop_back();
  endtask

  // Send the body as byte transfers, the last one flagged.
  task send_body();
    int i;
    int gap;
    for (i = 0; i < body_q.size(); i++) begin
      gap = draw_wait(tx_quiet);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= body_q[i];
      in_tlast  <= (i == body_q.size() - 1);
      do @(posedge clk); while (!in_tready);
    end
  endtask

  task directed_frames();
    // Short bodies: a single byte, and one byte below the minimum.
    body_q.delete();
    body_q.push_back(8'hA5);
    send_body();
    begin_body(64'h0123_4567_89AB_CDEF, 16'h0064, 16'h0431);
    add_ie(EID_SSID, 8'd4, -1);
    add_ie(EID_HT, 8'd5, -1);
    pad_body(35);
    cut_body(35);
    send_body();

    // Exactly the minimum length with all-ones fixed fields.
    begin_body('1, '1, '1);
    add_ie(EID_SSID, 8'd22, -1);
    send_body();

    // All-zero fixed fields and zero-length elements.
    begin_body('0, '0, '0);
    add_ie(EID_SSID, 8'd0, -1);
    add_ie(EID_HT, 8'd0, -1);
    add_ie(EID_VHT, 8'd0, -1);
    add_ie(EID_EXT, 8'd0, -1);
    pad_body(36);
    send_body();

    // Longest SSID, then an oversized one that must be ignored.
    begin_body({$urandom, $urandom}, 16'($urandom), 16'($urandom));
    add_ie(EID_SSID, 8'd32, -1);
    add_ie(EID_SSID, 8'd33, -1);
    pad_body(40);
    send_body();

    // Several SSIDs: the last acceptable one wins.
    begin_body({$urandom, $urandom}, 16'($urandom), 16'($urandom));
    add_ie(EID_SSID, 8'd5, -1);
    add_ie(EID_SSID, 8'd3, -1);
    add_ie(EID_SSID, 8'd255, -1);
    pad_body(40);
    send_body();

    // Rates with the top bit set, overflow past the rate slots, and capability flags.
    begin_body({$urandom, $urandom}, 16'($urandom), 16'($urandom));
    body_q.push_back(EID_RATES);
    body_q.push_back(8'd8);
    body_q.push_back(8'hFF);
    body_q.push_back(8'h80);
    body_q.push_back(8'h82);
    body_q.push_back(8'h84);
    body_q.push_back(8'h8B);
    body_q.push_back(8'h96);
    body_q.push_back(8'h0C);
    body_q.push_back(8'h7F);
    add_ie(EID_EXT_RATES, 8'd12, -1);
    add_ie(EID_RATES, 8'd3, -1);
    add_ie(EID_HT, 8'd26, -1);
    add_ie(EID_VHT, 8'd12, -1);
    add_ie(EID_EXT, 8'd3, int'(EXT_ID_HE));
    send_body();

    // Extension elements that do not announce HE.
    begin_body({$urandom, $urandom}, 16'($urandom), 16'($urandom));
    add_ie(EID_EXT, 8'd4, 36);
    body_q.push_back(EID_EXT);
    body_q.push_back(8'd3);
    body_q.push_back(8'd0);
    body_q.push_back(EXT_ID_HE);
    body_q.push_back(8'd0);
    pad_body(40);
    send_body();

    // SSID element cut off by the end of the frame.
    begin_body({$urandom, $urandom}, 16'($urandom), 16'($urandom));
    add_ie(EID_SSID, 8'd4, -1);
    add_ie(EID_RATES, 8'd4, -1);
    pad_body(40);
    add_ie(EID_SSID, 8'd10, -1);
    cut_body(body_q.size() - 5);
    send_body();

    // Rate element cut off by the end of the frame.
    begin_body({$urandom, $urandom}, 16'($urandom), 16'($urandom));
    add_ie(EID_RATES, 8'd3, -1);
    pad_body(40);
    add_ie(EID_EXT_RATES, 8'd6, -1);
    cut_body(body_q.size() - 3);
    send_body();

    // HE element cut off after its extension id.
    begin_body({$urandom, $urandom}, 16'($urandom), 16'($urandom));
    pad_body(40);
    add_ie(EID_EXT, 8'd4, int'(EXT_ID_HE));
    cut_body(body_q.size() - 2);
    send_body();

    // HT element ending on its length byte.
    begin_body({$urandom, $urandom}, 16'($urandom), 16'($urandom));
    pad_body(40);
    add_ie(EID_HT, 8'd5, -1);
    cut_body(body_q.size() - 5);
    send_body();

    // A lone element id at the very end is ignored.
    begin_body({$urandom, $urandom}, 16'($urandom), 16'($urandom));
    add_ie(EID_SSID, 8'd2, -1);
    pad_body(40);
    body_q.push_back(EID_HT);
    send_body();

    // Body longer than the byte counter range; parsing continues past saturation.
    begin_body({$urandom, $urandom}, 16'($urandom), 16'($urandom));
    add_ie(EID_SSID, 8'd6, -1);
    pad_body(4100);
    add_ie(EID_SSID, 8'd7, -1);
    add_ie(EID_RATES, 8'd2, -1);
    send_body();
  endtask

  // Mostly well-formed bodies with random content; some cut off, short or noise.
  task random_frame();
    logic [7:0] cut_ids [0:5];
    int mode;
    int len;
    cut_ids = '{EID_SSID, EID_RATES, EID_EXT_RATES, EID_HT, EID_VHT, EID_EXT};
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      body_q.delete();
      repeat ($urandom_range(1, 80)) body_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      begin_body({$urandom, $urandom}, 16'($urandom), 16'($urandom));
      repeat ($urandom_range(0, 7)) begin
        case ($urandom_range(0, 9))
          0, 1: add_ie(EID_SSID, 8'($urandom_range(0, 36)), -1);
          2: add_ie(EID_RATES, 8'($urandom_range(0, 10)), -1);
          3: add_ie(EID_EXT_RATES, 8'($urandom_range(0, 10)), -1);
          4: add_ie(EID_HT, 8'($urandom_range(0, 26)), -1);
          5: add_ie(EID_VHT, 8'($urandom_range(0, 12)), -1);
          6: add_ie(EID_EXT, 8'($urandom_range(0, 6)),
                    ($urandom_range(0, 2) != 0) ? int'(EXT_ID_HE) : -1);
          7: add_ie(8'($urandom_range(0, 255)), 8'($urandom_range(0, 40)), -1);
          default: add_ie(8'($urandom_range(0, 255)), 8'($urandom_range(0, 20)), -1);
        endcase
      end
      if (mode <= 13) begin
        pad_body($urandom_range(36, 60));
      end else if (mode <= 16) begin
        pad_body($urandom_range(36, 50));
        len = $urandom_range(1, 20);
        add_ie(cut_ids[$urandom_range(0, 5)], len[7:0], int'(EXT_ID_HE));
        cut_body(body_q.size() - $urandom_range(1, len));
      end else if (mode <= 18) begin
        cut_body($urandom_range(1, 35));
      end else begin
        pad_body(40);
        body_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Result sink: random stalls, plus one long hold-off that backs up the input.
  initial begin : result_sink
    int wait_cycles;
    int taken;
    taken = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      wait_cycles = draw_wait(rx_quiet);
      if (taken == LONG_HOLD_AFTER) wait_cycles = LONG_HOLD_CYCLES;
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // Reset, stimulus, drain and verdict.
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    directed_frames();
    repeat (RANDOM_FRAMES) begin
      random_frame();
      send_body();
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    wait (reports_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("beacon_body_ie_parser_top: match");
    end else begin
      $display("beacon_body_ie_parser_top: mismatch");
    end
    $finish;
  end

endmodule
